[design/plc_pkg.sv]
// Package for the positional list store: request and status codes and the
// command that the control logic broadcasts to the storage cells.
// No dependencies.
package plc_pkg;

  localparam int REQ_W  = 3;
  localparam int IN_W   = 32;
  localparam int POS_W  = 8;
  localparam int STAT_W = 2;
  localparam int LCNT_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_POS   = 3'd5,
    REQ_COUNT     = 3'd6,
    REQ_READ      = 3'd7
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [POS_W-1:0]   idx;
    logic [POS_W-1:0]   last;
  } cell_cmd_t;

endpackage

[design/plc_cell.sv]
// One storage cell of the list chain: holds the element at a fixed list index
// and on insert, delete and rotate takes a neighbor, new or head word.
// Depends on plc_pkg.
module plc_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  logic                    clk,
  input  plc_pkg::cell_cmd_t      cmd,
  input  logic [DATA_WIDTH-1:0]   new_value,
  input  logic [DATA_WIDTH-1:0]   prev_value,
  input  logic [DATA_WIDTH-1:0]   next_value,
  input  logic [DATA_WIDTH-1:0]   head_value,
  output logic [DATA_WIDTH-1:0]   value
);
  import plc_pkg::*;

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

  logic [DATA_WIDTH-1:0] value_next;

  always_comb begin
    value_next = value;
    unique case (cmd.op)
      OP_INS: begin
        if (MY_IDX == cmd.idx) begin
          value_next = new_value;
        end else if (MY_IDX > cmd.idx) begin
          value_next = prev_value;
        end
      end
      OP_DEL: begin
        if (MY_IDX >= cmd.idx) begin
          value_next = next_value;
        end
      end
      OP_ROT: begin
        if (MY_IDX == cmd.last) begin
          value_next = head_value;
        end else if (MY_IDX < cmd.last) begin
          value_next = next_value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

[design/positional_list_store_core.sv]
// Top level of the positional list store: request decode, count, read-out
// sequencer and output register around a chain of plc_cell storage cells.
// Depends on plc_pkg and plc_cell.
//
//  channel  | dir | tdata (low bit up)                      | tuser    | tlast
//  s_axis   | in  | item_value[31:0], position[39:32]       | req_type | -
//  m_axis   | out | out_value[31:0], list_count[36:32], pad | status   | is_last
//
// Insert and delete requests shift the cells from the target index on in their
// accept cycle; count requests shift none. A read-out of a non-empty list loads
// no result in its accept cycle, then one result per stored element, the chain
// rotating one place per result; nothing is accepted until the last result
// leaves. Output stalls hold the read-out in place. Reset empties the list.
module positional_list_store_core #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // item_value[31:0], position[39:32]
  input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_value[31:0], list_count[36:32], zeros
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic        m_axis_tlast    // is_last
);
  import plc_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                 state, state_next;
  logic [CW-1:0]          count, count_next;
  logic [CW-1:0]          rd_cnt, rd_cnt_next;
  logic                   out_free;
  logic                   in_acc;
  req_t                   req;
  logic signed [IN_W-1:0] item_value;
  logic [POS_W-1:0]       position;
  logic [POS_W:0]         cnt_ext;
  logic                   full, empty, ins_pos_ok, del_pos_ok;
  cell_cmd_t              cmd;
  status_t                st;
  logic                   load_out;
  status_t                o_status, o_status_next;
  logic [IN_W-1:0]        o_value, o_value_next;
  logic [LCNT_W-1:0]      o_count_next;
  logic [LCNT_W-1:0]      o_count;
  logic                   o_last, o_last_next;
  logic [DATA_WIDTH-1:0]  new_value;
  logic [DATA_WIDTH-1:0]  cell_q [CAPACITY];

  assign req        = req_t'(s_axis_tuser);
  assign item_value = s_axis_tdata[IN_W-1:0];
  assign position   = s_axis_tdata[IN_W+POS_W-1:IN_W];
  assign new_value  = DATA_WIDTH'(item_value);

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign cnt_ext    = (POS_W + 1)'(count);
  assign full       = (count == CW'(CAPACITY));
  assign empty      = (count == '0);
  assign ins_pos_ok = (position != '0) && ((POS_W + 1)'(position) <= cnt_ext + 1'b1);
  assign del_pos_ok = (position != '0) && ((POS_W + 1)'(position) <= cnt_ext);

  always_comb begin
    state_next    = state;
    count_next    = count;
    rd_cnt_next   = rd_cnt;
    cmd.op        = OP_HOLD;
    cmd.idx       = '0;
    cmd.last      = POS_W'(count) - 1'b1;
    st            = ST_OK;
    load_out      = 1'b0;
    o_status_next = ST_OK;
    o_value_next  = '0;
    o_last_next   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          load_out = 1'b1;
          unique case (req)
            REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
              if (req == REQ_INS_POS && !ins_pos_ok) begin
                st = ST_BAD_POS;
              end else if (full) begin
                st = ST_FULL;
              end else begin
                cmd.op     = OP_INS;
                cmd.idx    = (req == REQ_INS_FRONT) ? '0 :
                             (req == REQ_INS_BACK)  ? POS_W'(count) :
                                                      position - 1'b1;
                count_next = count + 1'b1;
              end
            end
            REQ_DEL_FRONT, REQ_DEL_BACK: begin
              if (empty) begin
                st = ST_EMPTY;
              end else begin
                cmd.op     = OP_DEL;
                cmd.idx    = (req == REQ_DEL_FRONT) ? '0 : POS_W'(count) - 1'b1;
                count_next = count - 1'b1;
              end
            end
            REQ_DEL_POS: begin
              if (!del_pos_ok) begin
                st = ST_BAD_POS;
              end else begin
                cmd.op     = OP_DEL;
                cmd.idx    = position - 1'b1;
                count_next = count - 1'b1;
              end
            end
            REQ_COUNT: st = ST_OK;
            REQ_READ: begin
              if (empty) begin
                st = ST_EMPTY;
              end else begin
                load_out    = 1'b0;
                rd_cnt_next = '0;
                state_next  = S_READ;
              end
            end
            default: st = ST_OK;
          endcase
          o_status_next = st;
        end
      end
      S_READ: begin
        if (out_free) begin
          load_out     = 1'b1;
          cmd.op       = OP_ROT;
          o_value_next = IN_W'($signed(cell_q[0]));
          o_last_next  = (rd_cnt == count - 1'b1);
          rd_cnt_next  = rd_cnt + 1'b1;
          if (o_last_next) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    o_count_next = LCNT_W'(count_next);
  end

  genvar j;
  generate
    for (j = 0; j < CAPACITY; j++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_w, next_w;
      if (j == 0) begin : g_first
        assign prev_w = new_value;
      end else begin : g_mid_prev
        assign prev_w = cell_q[j-1];
      end
      if (j == CAPACITY - 1) begin : g_last
        assign next_w = cell_q[j];
      end else begin : g_mid_next
        assign next_w = cell_q[j+1];
      end
      plc_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .INDEX      (j)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .new_value  (new_value),
        .prev_value (prev_w),
        .next_value (next_w),
        .head_value (cell_q[0]),
        .value      (cell_q[j])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      rd_cnt        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_cnt <= rd_cnt_next;
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_status <= o_status_next;
      o_value  <= o_value_next;
      o_count  <= o_count_next;
      o_last   <= o_last_next;
    end
  end

  assign m_axis_tdata = {3'b000, o_count, o_value};
  assign m_axis_tuser = o_status;
  assign m_axis_tlast = o_last;

endmodule

[bench/tb.sv]
// Self-checking bench for positional_list_store_core: directed and random
// list requests over the stream ports, each checked against a queue-based list predictor.
// Depends on plc_pkg and positional_list_store_core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plc_pkg::*;

  localparam int CAP = 16;
  localparam int DW  = 32;

  typedef struct {
    status_t            status;
    logic signed [31:0] value;
    logic [4:0]         count;
    logic               last;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // item_value[31:0], position[39:32]
  logic [2:0]  s_axis_tuser = '0;   // req_type[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // out_value[31:0], list_count[36:32], zeros
  logic [1:0]  m_axis_tuser;        // status[1:0]
  logic        m_axis_tlast;        // is_last

  logic signed [DW-1:0] list_words[$];
  list_result_t         expected_q[$];
  int                   errors = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   hold_off_req = 0;
  int                   stall_left = 0;

  positional_list_store_core #(
    .CAPACITY  (CAP),
    .DATA_WIDTH(DW)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  function automatic void push_result(status_t st, logic signed [31:0] val, logic last);
    list_result_t res;
    int           n;
    n          = list_words.size();
    res.status = st;
    res.value  = val;
    res.count  = n[4:0];
    res.last   = last;
    expected_q.push_back(res);
  endfunction

  function automatic void predict_list_request(req_t req, logic signed [31:0] val,
                                               logic [7:0] pos);
    status_t              st;
    int                   n;
    int                   idx;
    logic signed [DW-1:0] word;
    logic signed [31:0]   shown;
    st   = ST_OK;
    n    = list_words.size();
    word = val;
    case (req)
      REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
        idx = (req == REQ_INS_FRONT) ? 0 : (req == REQ_INS_BACK) ? n : int'(pos) - 1;
        if (req == REQ_INS_POS && (pos < 1 || int'(pos) > n + 1)) st = ST_BAD_POS;
        else if (n >= CAP) st = ST_FULL;
        else list_words.insert(idx, word);
      end
      REQ_DEL_FRONT: begin
        if (n == 0) st = ST_EMPTY;
        else list_words.delete(0);
      end
      REQ_DEL_BACK: begin
        if (n == 0) st = ST_EMPTY;
        else list_words.delete(n - 1);
      end
      REQ_DEL_POS: begin
        if (pos < 1 || int'(pos) > n) st = ST_BAD_POS;
        else list_words.delete(int'(pos) - 1);
      end
      REQ_COUNT: ;
      REQ_READ: begin
        if (n == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            shown = list_words[i];
            push_result(ST_OK, shown, i == n - 1);
          end
        end
        return;
      end
      default: ;
    endcase
    push_result(st, '0, 1'b1);
  endfunction

  // Called and returns at a rising edge; valid stays high into the next call.
  task automatic send_request(req_t req, logic signed [31:0] val, logic [7:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, val};
    s_axis_tuser  <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_list_request(req, val, pos);
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_error(string what, list_result_t exp_res, list_result_t got);
    if (errors < 10)
      $display("tb: %s: expected st=%0d val=%0d cnt=%0d last=%0b, %s",
               what, exp_res.status, exp_res.value, exp_res.count, exp_res.last,
               $sformatf("got st=%0d val=%0d cnt=%0d last=%0b",
                         got.status, got.value, got.count, got.last));
    errors++;
  endtask

  always @(posedge clk) begin
    list_result_t got;
    list_result_t exp_res;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = status_t'(m_axis_tuser);
      got.value  = m_axis_tdata[31:0];
      got.count  = m_axis_tdata[36:32];
      got.last   = m_axis_tlast;
      if (expected_q.size() == 0) begin
        exp_res = '{ST_OK, '0, '0, 1'b0};
        report_error("unexpected result", exp_res, got);
      end else begin
        exp_res = expected_q.pop_front();
        if (got.status != exp_res.status || got.value != exp_res.value ||
            got.count != exp_res.count || got.last != exp_res.last)
          report_error("mismatch", exp_res, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off_req != 0) begin
      stall_left   = hold_off_req;
      hold_off_req = 0;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_directed();
    send_request(REQ_READ,      pick_word(), 8'd0);
    send_request(REQ_DEL_FRONT, pick_word(), 8'd0);
    send_request(REQ_DEL_BACK,  pick_word(), 8'd0);
    send_request(REQ_DEL_POS,   pick_word(), 8'd1);
    send_request(REQ_DEL_POS,   pick_word(), 8'd0);
    send_request(REQ_INS_POS,   32'sh1234_5678, 8'd0);
    send_request(REQ_INS_POS,   32'sh1234_5678, 8'd2);
    send_request(REQ_INS_POS,   32'sh8000_0000, 8'd1);
    send_request(REQ_INS_FRONT, 32'sh7fff_ffff, 8'd0);
    send_request(REQ_INS_BACK,  -32'sd1,        8'd255);
    send_request(REQ_INS_POS,   32'sd0,         8'd4);
    send_request(REQ_INS_POS,   32'sh5a5a_a5a5, 8'd2);
    send_request(REQ_INS_POS,   32'sh0f0f_f0f0, 8'd255);
    send_request(REQ_COUNT,     pick_word(), 8'd0);
    send_request(REQ_READ,      pick_word(), 8'd0);
    send_request(REQ_DEL_POS,   pick_word(), 8'd6);
    send_request(REQ_DEL_POS,   pick_word(), 8'd5);
    send_request(REQ_DEL_POS,   pick_word(), 8'd1);
    send_request(REQ_DEL_POS,   pick_word(), 8'd255);
    send_request(REQ_DEL_BACK,  pick_word(), 8'd0);
    send_request(REQ_DEL_FRONT, pick_word(), 8'd0);
    send_request(REQ_READ,      pick_word(), 8'd0);
    send_request(REQ_DEL_FRONT, pick_word(), 8'd0);
    send_request(REQ_COUNT,     32'sh8000_0000, 8'd255);
  endtask

  task automatic test_full_list();
    while (list_words.size() < CAP) send_request(REQ_INS_BACK, pick_word(), 8'($urandom));
    send_request(REQ_INS_FRONT, pick_word(), 8'd0);
    send_request(REQ_INS_BACK,  pick_word(), 8'd0);
    send_request(REQ_INS_POS,   pick_word(), 8'(CAP + 1));
    send_request(REQ_INS_POS,   pick_word(), 8'(CAP + 2));
    send_request(REQ_INS_POS,   pick_word(), 8'd0);
    send_request(REQ_READ,      pick_word(), 8'd0);
    send_request(REQ_DEL_POS,   pick_word(), 8'(CAP));
    send_request(REQ_INS_POS,   pick_word(), 8'(CAP));
    send_request(REQ_COUNT,     pick_word(), 8'd0);
  endtask

  task automatic test_random(int n_items);
    int   pick;
    int   n;
    bit   grow;
    req_t req;
    logic [7:0] pos;
    grow = $urandom_range(1);
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 39) grow = !grow;
      n    = list_words.size();
      pick = $urandom_range(99);
      if (pick < (grow ? 55 : 30))  req = req_t'($urandom_range(2));
      else if (pick < 85)           req = req_t'(3 + $urandom_range(2));
      else if (pick < 90)           req = REQ_COUNT;
      else                          req = REQ_READ;
      if ($urandom_range(99) < 15)  pos = 8'($urandom_range(255));
      else if (req == REQ_INS_POS)  pos = 8'($urandom_range(n + 1, 1));
      else if (n > 0)               pos = 8'($urandom_range(n, 1));
      else                          pos = 8'($urandom_range(255));
      send_request(req, pick_word(), pos);
    end
  endtask

  task automatic test_backpressure();
    hold_off_req = 120;
    send_request(REQ_READ, pick_word(), 8'd0);
    test_random(30);
    send_request(REQ_READ, pick_word(), 8'd0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 18;
    recv_idle_pct = 62;
    test_directed();
    test_full_list();
    test_random(120);
    send_idle_pct = 62;
    recv_idle_pct = 18;
    test_random(120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(50);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    errors += expected_q.size();
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
